FILE: hw/rtl/iolh_pkg.sv
// Package: widths, constants and state codes for the I/O latency histogram block.
`timescale 1ns / 1ps
package iolh_pkg;
  localparam int unsigned JobSlotsDefault = 64;
  localparam int unsigned LatBuckets = 48;
  localparam int unsigned QuoW = 31;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_RDW   = 8'b0000_1000,
    ST_SRCH  = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_BKT   = 8'b0100_0000,
    ST_WR    = 8'b1000_0000
  } state_t;
endpackage

FILE: hw/rtl/io_latency_histogram_running_mean.sv
// Top level: per-job byte totals, running mean and latency histogram.
//
//   channel | ports                                     | handshake
//   input   | in_job_slot in_is_write in_byte_count ... | start && !busy
//   result  | out_accounted ... out_bucket_count        | out_valid, one cycle
//
// An accounted event keeps busy high through the steps below, and its result
// is strobed as busy drops; only then is a new event accepted. The steps are
// the read states ST_RD and ST_RDW, a 6-step binary search of the latency over
// a threshold table, a 31-step restoring divide of the mean difference by the
// count, a bucket read and a write-back; the search and the divide share one
// subtract unit. Without accounting the divide is skipped.
// After reset a clearing pass zeroes the stores; busy stays high meanwhile.
// Results cannot be stalled: out_valid lasts one cycle.
`timescale 1ns / 1ps
module io_latency_histogram_running_mean #(
  parameter int unsigned JOB_SLOTS = iolh_pkg::JobSlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_job_slot,
  input  logic        in_is_write,
  input  logic signed [31:0] in_byte_count,
  input  logic [39:0] in_latency_ns,
  output logic        out_valid,
  output logic        out_accounted,
  output logic [63:0] out_byte_total,
  output logic [31:0] out_op_count,
  output logic [30:0] out_mean_bytes,
  output logic [5:0]  out_bucket_index,
  output logic [31:0] out_bucket_count
);
  import iolh_pkg::*;

  localparam int unsigned Entries = 2 * JOB_SLOTS;
  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned LDepth = Entries * LatBuckets;
  localparam int unsigned LW = $clog2(LDepth);
  localparam int unsigned CW = LW + 1;

  logic [63:0] tot_mem [Entries];
  logic [31:0] cnt_mem [Entries];
  logic [30:0] mean_mem [Entries];
  logic [31:0] lat_mem [LDepth];

  state_t state_r, state_nxt;
  logic [CW-1:0] clr_r;
  logic [EW-1:0] ent_r;
  logic acc_r;
  logic [30:0] x_r;
  logic [39:0] lat_r;
  logic [63:0] tot_r;
  logic [31:0] cnt_r;
  logic [30:0] mean_r;
  logic [31:0] bcnt_r;
  logic [5:0] bkt_r;
  logic [LW-1:0] li_r;
  logic [5:0] step_r;
  logic [30:0] quo_r;
  logic [31:0] rem_r;
  logic neg_r;
  logic out_valid_r;

  // lower latency bound in ns of each bucket; entries past the last bucket
  // sit above any 40-bit latency
  function automatic logic [40:0] lat_thr(input logic [5:0] k);
    logic [40:0] t;
    case (k)
      6'd1:    t = 41'd1000;
      6'd2:    t = 41'd11000;
      6'd3:    t = 41'd21000;
      6'd4:    t = 41'd31000;
      6'd5:    t = 41'd41000;
      6'd6:    t = 41'd51000;
      6'd7:    t = 41'd61000;
      6'd8:    t = 41'd71000;
      6'd9:    t = 41'd81000;
      6'd10:   t = 41'd91000;
      6'd11:   t = 41'd100000;
      6'd12:   t = 41'd200000;
      6'd13:   t = 41'd300000;
      6'd14:   t = 41'd400000;
      6'd15:   t = 41'd500000;
      6'd16:   t = 41'd600000;
      6'd17:   t = 41'd700000;
      6'd18:   t = 41'd800000;
      6'd19:   t = 41'd900000;
      6'd20:   t = 41'd1000000;
      6'd21:   t = 41'd2000000;
      6'd22:   t = 41'd3000000;
      6'd23:   t = 41'd4000000;
      6'd24:   t = 41'd5000000;
      6'd25:   t = 41'd6000000;
      6'd26:   t = 41'd7000000;
      6'd27:   t = 41'd8000000;
      6'd28:   t = 41'd9000000;
      6'd29:   t = 41'd10000000;
      6'd30:   t = 41'd20000000;
      6'd31:   t = 41'd30000000;
      6'd32:   t = 41'd40000000;
      6'd33:   t = 41'd50000000;
      6'd34:   t = 41'd60000000;
      6'd35:   t = 41'd70000000;
      6'd36:   t = 41'd80000000;
      6'd37:   t = 41'd90000000;
      6'd38:   t = 41'd100000000;
      6'd39:   t = 41'd200000000;
      6'd40:   t = 41'd300000000;
      6'd41:   t = 41'd400000000;
      6'd42:   t = 41'd500000000;
      6'd43:   t = 41'd600000000;
      6'd44:   t = 41'd700000000;
      6'd45:   t = 41'd800000000;
      6'd46:   t = 41'd900000000;
      6'd47:   t = 41'd1000000000;
      default: t = 41'h100_0000_0000;
    endcase
    return t;
  endfunction

  // fold the slot number into the configured slot range
  function automatic logic [5:0] slot_fold(input logic [5:0] s);
    logic [5:0] f;
    f = '0;
    for (int i = 0; i < 64; i++) begin
      if (s == 6'(i)) f = 6'(i % JOB_SLOTS);
    end
    return f;
  endfunction

  logic [5:0] cand;
  assign cand = bkt_r | (6'd32 >> step_r);

  // shared subtract unit
  logic [40:0] sub_a, sub_b, sub_d;
  assign sub_d = sub_a - sub_b;
  always_comb begin
    sub_a = {8'd0, rem_r, quo_r[30]};
    sub_b = {9'd0, cnt_r};
    if (state_r == ST_SRCH) begin
      sub_a = {1'b0, lat_r};
      sub_b = lat_thr(cand);
    end
  end

  logic [EW-1:0] in_ent;
  always_comb begin
    in_ent = EW'({slot_fold(in_job_slot), in_is_write});
  end

  logic [LW-1:0] li_c;
  assign li_c = LW'({ent_r, 6'd0} - {ent_r, 4'd0} + {{EW{1'b0}}, bkt_r});

  logic [30:0] mean_new;
  always_comb mean_new = neg_r ? (mean_r - quo_r) : (mean_r + quo_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == CW'(LDepth - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_RDW;
      ST_RDW:   state_nxt = ST_SRCH;
      ST_SRCH:  if (step_r == 6'd5) state_nxt = acc_r ? ST_DIV : ST_BKT;
      ST_DIV:   if (step_r == 6'd30) state_nxt = ST_BKT;
      ST_BKT:   state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == ST_WR);
      if (state_r == ST_CLEAR) clr_r <= clr_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      lat_mem[clr_r[LW-1:0]] <= '0;
      if (clr_r < CW'(Entries)) begin
        tot_mem[clr_r[EW-1:0]] <= '0;
        cnt_mem[clr_r[EW-1:0]] <= '0;
        mean_mem[clr_r[EW-1:0]] <= '0;
      end
    end
    case (state_r)
      ST_IDLE: if (start) begin
        ent_r <= in_ent;
        acc_r <= (in_byte_count > 32'sd0);
        x_r <= in_byte_count[30:0];
        lat_r <= in_latency_ns;
        step_r <= '0;
        rem_r <= '0;
        bkt_r <= '0;
      end
      ST_RD: begin
        tot_r <= tot_mem[ent_r];
        cnt_r <= cnt_mem[ent_r];
        mean_r <= mean_mem[ent_r];
      end
      ST_RDW: begin
        // apply byte and count updates, set up the sign of the mean difference
        if (acc_r) begin
          tot_r <= ({1'b0, tot_r} + {33'd0, x_r} > 65'hFFFF_FFFF_FFFF_FFFF) ? '1
                   : tot_r + {33'd0, x_r};
          if (cnt_r != '1) cnt_r <= cnt_r + 32'd1;
        end
        neg_r <= x_r < mean_r;
      end
      ST_SRCH: begin
        // binary search: keep the candidate bucket if its bound is reached
        if (!sub_d[40]) bkt_r <= cand;
        step_r <= step_r + 6'd1;
        if (step_r == 6'd5) begin
          step_r <= '0;
          rem_r <= '0;
          quo_r <= neg_r ? (mean_r - x_r) : (x_r - mean_r);
        end
      end
      ST_DIV: begin
        // restoring divide: dividend shifts out of quo_r top, quotient in
        if (!sub_d[40]) begin
          rem_r <= sub_d[31:0];
          quo_r <= {quo_r[29:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[30]};
          quo_r <= {quo_r[29:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
      end
      ST_BKT: begin
        li_r <= li_c;
        bcnt_r <= lat_mem[li_c];
        if (acc_r) mean_r <= mean_new;
      end
      ST_WR: begin
        if (bcnt_r != '1) bcnt_r <= bcnt_r + 32'd1;
        if (bcnt_r != '1) lat_mem[li_r] <= bcnt_r + 32'd1;
        tot_mem[ent_r] <= tot_r;
        cnt_mem[ent_r] <= cnt_r;
        mean_mem[ent_r] <= mean_r;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_accounted = acc_r;
  assign out_byte_total = tot_r;
  assign out_op_count = cnt_r;
  assign out_mean_bytes = mean_r;
  assign out_bucket_index = bkt_r;
  assign out_bucket_count = bcnt_r;
endmodule

FILE: sim/tb_top.sv
// Testbench for the I/O latency histogram block: directed table, then random events.
`timescale 1ns / 1ps
module tb_top;
  import iolh_pkg::*;

  localparam int unsigned SLOTS = JobSlotsDefault;
  localparam int unsigned ENTRIES = 2 * SLOTS;
  localparam int unsigned NUM_RANDOM = 1730;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [5:0]  in_job_slot;
  logic        in_is_write;
  logic signed [31:0] in_byte_count;
  logic [39:0] in_latency_ns;
  logic        out_valid;
  logic        out_accounted;
  logic [63:0] out_byte_total;
  logic [31:0] out_op_count;
  logic [30:0] out_mean_bytes;
  logic [5:0]  out_bucket_index;
  logic [31:0] out_bucket_count;

  io_latency_histogram_running_mean uut (
    .clk, .rst_n, .start, .busy,
    .in_job_slot, .in_is_write, .in_byte_count, .in_latency_ns,
    .out_valid, .out_accounted, .out_byte_total, .out_op_count,
    .out_mean_bytes, .out_bucket_index, .out_bucket_count
  );

  typedef struct packed {
    logic        accounted;
    logic [63:0] byte_total;
    logic [31:0] op_count;
    logic [30:0] mean_bytes;
    logic [5:0]  bucket_index;
    logic [31:0] bucket_count;
  } io_stats_t;

  typedef struct {
    logic [5:0]  slot;
    logic        wr;
    logic [31:0] bytes;
    logic [39:0] lat;
    bit          typed;
    io_stats_t   want;
  } event_row_t;

  // shadow of the per-entry stores
  logic [63:0] sh_bytes [ENTRIES];
  logic [31:0] sh_ops [ENTRIES];
  logic [30:0] sh_mean [ENTRIES];
  logic [31:0] sh_lat [ENTRIES * LatBuckets];

  io_stats_t stats_q [$];
  int        err_count;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [5:0] lat_bin_of(input logic [39:0] ns);
    logic [39:0] us;
    us = ns / 1000;
    if (us < 1) return 6'd0;
    if (us < 100) return 6'(1 + (us - 1) / 10);
    if (us < 1000) return 6'(11 + (us - 100) / 100);
    if (us < 10000) return 6'(20 + (us - 1000) / 1000);
    if (us < 100000) return 6'(29 + (us - 10000) / 10000);
    if (us < 1000000) return 6'(38 + (us - 100000) / 100000);
    return 6'd47;
  endfunction

  function automatic io_stats_t account_event(input logic [5:0] slot, input logic wr,
                                              input logic [31:0] bytes,
                                              input logic [39:0] lat);
    io_stats_t   r;
    int unsigned e;
    int unsigned li;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] step;
    e = (slot % SLOTS) * 2 + wr;
    r.accounted = (bytes != 0) && !bytes[31];
    if (r.accounted) begin
      x = {32'd0, bytes};
      m = {33'd0, sh_mean[e]};
      if (sh_bytes[e] > 64'hFFFF_FFFF_FFFF_FFFF - x) sh_bytes[e] = '1;
      else sh_bytes[e] += x;
      if (sh_ops[e] != 32'hFFFF_FFFF) sh_ops[e] += 1;
      if (x >= m) begin
        step = (x - m) / sh_ops[e];
        m += step;
      end else begin
        step = (m - x) / sh_ops[e];
        m -= step;
      end
      sh_mean[e] = m[30:0];
    end
    r.bucket_index = lat_bin_of(lat);
    li = e * LatBuckets + r.bucket_index;
    if (sh_lat[li] != 32'hFFFF_FFFF) sh_lat[li] += 1;
    r.byte_total = sh_bytes[e];
    r.op_count = sh_ops[e];
    r.mean_bytes = sh_mean[e];
    r.bucket_count = sh_lat[li];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // results cannot be stalled: check every strobe
  always @(posedge clk) begin
    io_stats_t w;
    if (rst_n && out_valid) begin
      if (stats_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'd0, 64'd0);
      end else begin
        w = stats_q.pop_front();
        if (out_accounted !== w.accounted)
          report_mismatch("accounted", out_accounted, w.accounted);
        if (out_byte_total !== w.byte_total)
          report_mismatch("byte_total", out_byte_total, w.byte_total);
        if (out_op_count !== w.op_count)
          report_mismatch("op_count", out_op_count, w.op_count);
        if (out_mean_bytes !== w.mean_bytes)
          report_mismatch("mean_bytes", out_mean_bytes, w.mean_bytes);
        if (out_bucket_index !== w.bucket_index)
          report_mismatch("bucket_index", out_bucket_index, w.bucket_index);
        if (out_bucket_count !== w.bucket_count)
          report_mismatch("bucket_count", out_bucket_count, w.bucket_count);
      end
    end
  end

  // hold one beat on the ports until accepted; the caller drops start
  task automatic send_event(input logic [5:0] slot, input logic wr,
                            input logic [31:0] bytes, input logic [39:0] lat,
                            input bit typed, input io_stats_t want);
    io_stats_t p;
    start <= 1'b1;
    in_job_slot <= slot;
    in_is_write <= wr;
    in_byte_count <= bytes;
    in_latency_ns <= lat;
    do @(posedge clk); while (busy);
    p = account_event(slot, wr, bytes, lat);
    if (typed && p !== want) report_mismatch("table row", 64'(p), 64'(want));
    stats_q.push_back(p);
  endtask

  function automatic logic [39:0] random_latency();
    case ($urandom_range(0, 7))
      0: return 40'($urandom_range(0, 999));
      1: return 40'($urandom_range(1000, 99_999));
      2: return 40'($urandom_range(100_000, 999_999));
      3: return 40'($urandom_range(1_000_000, 9_999_999));
      4: return 40'($urandom_range(10_000_000, 99_999_999));
      5: return 40'($urandom_range(100_000_000, 999_999_999));
      6: return {8'($urandom), 32'($urandom)};
      default: return 40'(1000 * $urandom_range(0, 1_000_000));
    endcase
  endfunction

  function automatic logic [31:0] random_bytes();
    case ($urandom_range(0, 9))
      0: return -32'(int'($urandom_range(0, 4096)));
      1: return 32'($urandom) & 32'h7FFF_FFFF;
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      3: return 32'($urandom);
      default: return 32'($urandom_range(1, 65536));
    endcase
  endfunction

  event_row_t rows [$];
  io_stats_t  z;

  initial begin
    event_row_t r;
    int gap;
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_job_slot = '0;
    in_is_write = 1'b0;
    in_byte_count = '0;
    in_latency_ns = '0;
    err_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_bytes[i] = '0; sh_ops[i] = '0; sh_mean[i] = '0;
    end
    for (int i = 0; i < ENTRIES * LatBuckets; i++) sh_lat[i] = '0;
    z = '0;

    // slot, dir, bytes, latency, typed, expected
    rows.push_back('{6'd0, 1'b0, 32'd100, 40'd0, 1, '{1, 64'd100, 32'd1, 31'd100, 6'd0, 32'd1}});
    rows.push_back('{6'd0, 1'b0, 32'd0, 40'd999, 1, '{0, 64'd100, 32'd1, 31'd100, 6'd0, 32'd2}});
    rows.push_back('{6'd63, 1'b1, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF, 1,
                     '{1, 64'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF, 6'd47, 32'd1}});
    rows.push_back('{6'd63, 1'b1, -32'sd4096, 40'd1_000_000_000, 1,
                     '{0, 64'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF, 6'd47, 32'd2}});
    rows.push_back('{6'd5, 1'b1, 32'h8000_0000, 40'd1000, 1, '{0, 0, 0, 0, 6'd1, 32'd1}});
    rows.push_back('{6'd5, 1'b0, 32'hFFFF_FFFF, 40'd99_999, 1, '{0, 0, 0, 0, 6'd10, 32'd1}});
    rows.push_back('{6'd5, 1'b0, 32'd1, 40'd100_000, 1, '{1, 1, 1, 1, 6'd11, 32'd1}});
    rows.push_back('{6'd7, 1'b0, 32'd1, 40'd999_999, 0, z});
    rows.push_back('{6'd7, 1'b0, 32'd1000, 40'd1_000_000, 0, z});
    rows.push_back('{6'd7, 1'b0, 32'd10, 40'd9_999_999, 0, z});
    rows.push_back('{6'd7, 1'b0, 32'd10, 40'd10_000_000, 0, z});
    rows.push_back('{6'd7, 1'b0, 32'd3, 40'd99_999_999, 0, z});
    rows.push_back('{6'd7, 1'b0, 32'd500, 40'd100_000_000, 0, z});
    rows.push_back('{6'd7, 1'b0, 32'd499, 40'd999_999_999, 0, z});
    rows.push_back('{6'd42, 1'b1, 32'h5555_5555, 40'hAA_AAAA_AAAA, 0, z});
    rows.push_back('{6'd21, 1'b0, 32'h2AAA_AAAA, 40'h55_5555_5555, 0, z});
    rows.push_back('{6'd42, 1'b1, 32'd2, 40'd1_000_000_999, 0, z});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_event(rows[i].slot, rows[i].wr, rows[i].bytes, rows[i].lat,
                 rows[i].typed, rows[i].want);
    start <= 1'b0;

    // let everything drain once before the random part
    while (stats_q.size() != 0) @(posedge clk);

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
        r.slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
        r.wr = 1'($urandom);
        r.bytes = random_bytes();
        r.lat = random_latency();
        send_event(r.slot, r.wr, r.bytes, r.lat, 0, z);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (stats_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // clearing pass plus ~1750 events and gaps
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/iolh_pkg.sv
hw/rtl/io_latency_histogram_running_mean.sv
sim/tb_top.sv
